>>> rtl/agglomerative_linkage_clusterer_assert.svh
// Assertion macros used by the checker file.
`ifndef AGGLOMERATIVE_LINKAGE_CLUSTERER_ASSERT_SVH
`define AGGLOMERATIVE_LINKAGE_CLUSTERER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define ALC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alc check failed");

// Next-cycle implication, off while reset is high.
`define ALC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alc check failed");

`endif

>>> rtl/alc_pkg.sv
`timescale 1ns / 1ps
package alc_pkg;

  localparam int unsigned CELL_W     = 40;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned DVAL_W     = 36;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam longint unsigned MISSING_UNITS = 64'd1000000;
  localparam longint unsigned ABOVE_UNITS   = 64'd10000;
  localparam logic [63:0] MASK40 = 64'hFF_FFFF_FFFF;

  // request codes
  localparam logic [1:0] REQ_CELL  = 2'd0;
  localparam logic [1:0] REQ_SIZE  = 2'd1;
  localparam logic [1:0] REQ_MERGE = 2'd2;

  // linkage codes
  localparam logic [1:0] LINK_MAX  = 2'd0;
  localparam logic [1:0] LINK_AVG  = 2'd1;
  localparam logic [1:0] LINK_MEAN = 2'd2;
  localparam logic [1:0] LINK_MIN  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINKAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIMIL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [DVAL_W-1:0] distance_value;
    logic              missing_flag;
    logic [SIZE_W-1:0] cluster_size;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  merged_row;
    logic [IDX_W-1:0]  merged_col;
    logic [CELL_W-1:0] merge_distance;
    logic              pair_found;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_END, ST_CLEAR, ST_SZ_R, ST_SZ_C, ST_UPD_CHK,
    ST_UPD_RD_R, ST_UPD_RD_C, ST_UPD_CALC, ST_UPD_DIV, ST_UPD_WR_C,
    ST_UPD_WR_R, ST_SZ_WR_R, ST_SZ_WR_C, ST_DONE
  } seq_state_t;

  typedef enum logic [1:0] {DP_IDLE, DP_MUL, DP_DIV} div_phase_t;

  // row-major lower-triangle address of cell (a, b), a != b
  function automatic int unsigned tri_index(int unsigned a, int unsigned b);
    int unsigned hi;
    int unsigned lo;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    return ((hi * (hi - 1)) >> 1) + lo;
  endfunction

endpackage

>>> rtl/agglomerative_linkage_clusterer.sv
`timescale 1ns / 1ps
// Agglomerative linkage clusterer. Load the lower-triangle distance matrix one
// cell per item (req_type cell) and the cluster sizes one per item (req_type
// size); neither gives a result. A merge item scans every cell of the rows in
// use for the first strictly smallest value below cutoff + 10000 (Q.16),
// clears it, folds the absorbed column cluster into the row cluster under the
// chosen linkage, sums sizes and returns one result item. The matrix and the
// sizes sit in two single-port-write synchronous memories: the cell store of
// MAX_ITEMS*(MAX_ITEMS-1)/2 words and the size store. A merge reads the memory
// once per scanned cell, then updates each remaining cluster in turn; in
// average mode a bit-serial multiply and a 57-step restoring divide set the
// pace. Memory contents are undefined after reset; load every cell and size in
// use before the first merge. No input item is taken while a merge runs.
module agglomerative_linkage_clusterer #(
  parameter int unsigned MAX_ITEMS = alc_pkg::MAX_ITEMS_DEF,
  parameter int unsigned FRAC_BITS = alc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  alc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output alc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [alc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alc_pkg::CFG_W-1:0]      cfg_data
);
  localparam int unsigned CELLS = MAX_ITEMS * (MAX_ITEMS - 1) / 2;
  localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CL = alc_pkg::CELL_W;
  localparam int unsigned SW = alc_pkg::SIZE_W;
  localparam logic [63:0] MISS_RAW  = alc_pkg::MISSING_UNITS << FRAC_BITS;
  localparam logic [63:0] ABOVE_RAW = alc_pkg::ABOVE_UNITS << FRAC_BITS;
  localparam logic [CL-1:0] MISS_VAL =
    (MISS_RAW > alc_pkg::MASK40) ? alc_pkg::MASK40[CL-1:0] : MISS_RAW[CL-1:0];
  localparam logic [CL-1:0] ONE_VAL = CL'(1) << FRAC_BITS;

  // configuration
  logic [1:0]                       linkage_mode;
  logic [alc_pkg::COUNT_W-1:0]      item_count;
  logic                             similarity_input;
  logic [alc_pkg::CFG_W-1:0]        cutoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      linkage_mode     <= alc_pkg::LINK_MAX;
      item_count       <= alc_pkg::COUNT_W'(2);
      similarity_input <= 1'b0;
      cutoff           <= alc_pkg::CFG_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        alc_pkg::CFG_LINKAGE: linkage_mode     <= cfg_data[1:0];
        alc_pkg::CFG_COUNT:   item_count       <= cfg_data[alc_pkg::COUNT_W-1:0];
        alc_pkg::CFG_SIMIL:   similarity_input <= cfg_data[0];
        alc_pkg::CFG_CUTOFF:  cutoff           <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp item count, derive the cleared value
  int unsigned n_raw;
  logic [CW-1:0] n_use;
  logic [63:0]   above_sum;
  logic [CL-1:0] above;

  always_comb begin
    if (32'(item_count) < 2) n_raw = 2;
    else if (32'(item_count) > MAX_ITEMS) n_raw = MAX_ITEMS;
    else n_raw = 32'(item_count);
    n_use = n_raw[CW-1:0];
    above_sum = 64'(cutoff) + ABOVE_RAW;
    above = (above_sum > alc_pkg::MASK40) ? alc_pkg::MASK40[CL-1:0] : above_sum[CL-1:0];
  end

  // memories
  logic [CL-1:0] dist_mem [CELLS];
  logic [SW-1:0] size_mem [MAX_ITEMS];
  logic          d_we, s_we;
  logic [AW-1:0] d_addr_w, d_addr_r;
  logic [CL-1:0] d_wdata, d_rdata;
  logic [IW-1:0] s_addr_w, s_addr_r;
  logic [SW-1:0] s_wdata, s_rdata;

  always_ff @(posedge clk) begin
    if (d_we) dist_mem[d_addr_w] <= d_wdata;
    d_rdata <= dist_mem[d_addr_r];
  end

  always_ff @(posedge clk) begin
    if (s_we) size_mem[s_addr_w] <= s_wdata;
    s_rdata <= size_mem[s_addr_r];
  end

  // sequencer state
  alc_pkg::seq_state_t state, state_next;
  logic [CW-1:0] scan_i, scan_j, upd_i;
  logic [CW-1:0] p_i, p_j;
  logic          p_v;
  logic [CL-1:0] best;
  logic [IW-1:0] br, bc;
  logic          found;
  logic [SW-1:0] s_row, s_col;
  logic [CL-1:0] d_row, d_col, comb_val;
  logic          out_load;

  // averaging unit
  logic          div_start, div_done;
  logic [CL-1:0] div_quot;

  alc_avg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .d_row (d_row),
    .d_col (d_col),
    .s_row (s_row),
    .s_col (s_col),
    .done  (div_done),
    .quot  (div_quot)
  );

  // shared address generator: one triangle index per cycle
  int unsigned   tri_a, tri_b, tri_raw;
  logic          accept, cell_ok, size_ok;
  logic [CL-1:0] load_val;
  logic [CL:0]   pair_sum;
  logic [CL-1:0] simple_val;
  logic [SW:0]   size_sum;
  logic          scan_last;
  logic          skip_i;

  always_comb begin
    accept  = in_valid && !in_stall;
    cell_ok = (in_data.row_index != in_data.col_index) &&
              (32'(in_data.row_index) < MAX_ITEMS) &&
              (32'(in_data.col_index) < MAX_ITEMS);
    size_ok = (32'(in_data.row_index) < MAX_ITEMS);
    if (in_data.missing_flag) load_val = MISS_VAL;
    else if (similarity_input)
      load_val = (CL'(in_data.distance_value) < ONE_VAL) ?
                 (ONE_VAL - CL'(in_data.distance_value)) : '0;
    else load_val = CL'(in_data.distance_value);

    pair_sum = (CL+1)'(d_row) + (CL+1)'(d_col);
    case (linkage_mode)
      alc_pkg::LINK_MAX:  simple_val = (d_row > d_col) ? d_row : d_col;
      alc_pkg::LINK_MIN:  simple_val = (d_row < d_col) ? d_row : d_col;
      default:            simple_val = pair_sum[CL:1];
    endcase
    size_sum = (SW+1)'(s_row) + (SW+1)'(s_col);

    scan_last = (scan_j + 1'b1 == scan_i) && (scan_i + 1'b1 == n_use);
    skip_i = (upd_i == CW'(br)) || (upd_i == CW'(bc));

    tri_a = 32'(scan_i);
    tri_b = 32'(scan_j);
    case (state)
      alc_pkg::ST_IDLE: begin
        tri_a = 32'(in_data.row_index);
        tri_b = 32'(in_data.col_index);
      end
      alc_pkg::ST_CLEAR: begin
        tri_a = 32'(br);
        tri_b = 32'(bc);
      end
      alc_pkg::ST_UPD_CHK, alc_pkg::ST_UPD_WR_R: begin
        tri_a = 32'(upd_i);
        tri_b = 32'(br);
      end
      alc_pkg::ST_UPD_RD_R, alc_pkg::ST_UPD_WR_C: begin
        tri_a = 32'(upd_i);
        tri_b = 32'(bc);
      end
      default: ;
    endcase
    tri_raw = alc_pkg::tri_index(tri_a, tri_b);
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    d_we       = 1'b0;
    d_addr_w   = tri_raw[AW-1:0];
    d_addr_r   = tri_raw[AW-1:0];
    d_wdata    = above;
    s_we       = 1'b0;
    s_addr_w   = br;
    s_addr_r   = br;
    s_wdata    = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      alc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        s_addr_w = IW'(in_data.row_index);
        s_wdata  = in_data.cluster_size;
        d_wdata  = load_val;
        if (accept) begin
          case (in_data.req_type)
            alc_pkg::REQ_CELL:  d_we = cell_ok;
            alc_pkg::REQ_SIZE:  s_we = size_ok;
            alc_pkg::REQ_MERGE: state_next = alc_pkg::ST_SCAN;
            default: ;
          endcase
        end
      end
      alc_pkg::ST_SCAN: begin
        if (scan_last) state_next = alc_pkg::ST_SCAN_END;
      end
      alc_pkg::ST_SCAN_END: state_next = alc_pkg::ST_CLEAR;
      alc_pkg::ST_CLEAR: begin
        d_we = 1'b1;
        s_addr_r = br;
        state_next = alc_pkg::ST_SZ_R;
      end
      alc_pkg::ST_SZ_R: begin
        s_addr_r = bc;
        state_next = alc_pkg::ST_SZ_C;
      end
      alc_pkg::ST_SZ_C: state_next = alc_pkg::ST_UPD_CHK;
      alc_pkg::ST_UPD_CHK: begin
        if (upd_i == n_use) state_next = alc_pkg::ST_SZ_WR_R;
        else if (!skip_i) state_next = alc_pkg::ST_UPD_RD_R;
      end
      alc_pkg::ST_UPD_RD_R: state_next = alc_pkg::ST_UPD_RD_C;
      alc_pkg::ST_UPD_RD_C: state_next = alc_pkg::ST_UPD_CALC;
      alc_pkg::ST_UPD_CALC: begin
        if ((linkage_mode == alc_pkg::LINK_AVG) && (size_sum != '0)) begin
          div_start  = 1'b1;
          state_next = alc_pkg::ST_UPD_DIV;
        end else begin
          state_next = alc_pkg::ST_UPD_WR_C;
        end
      end
      alc_pkg::ST_UPD_DIV: begin
        if (div_done) state_next = alc_pkg::ST_UPD_WR_C;
      end
      alc_pkg::ST_UPD_WR_C: begin
        d_we = 1'b1;
        state_next = alc_pkg::ST_UPD_WR_R;
      end
      alc_pkg::ST_UPD_WR_R: begin
        d_we = 1'b1;
        d_wdata = comb_val;
        state_next = alc_pkg::ST_UPD_CHK;
      end
      alc_pkg::ST_SZ_WR_R: begin
        s_we = 1'b1;
        s_addr_w = br;
        s_wdata = size_sum[SW] ? {SW{1'b1}} : size_sum[SW-1:0];
        state_next = alc_pkg::ST_SZ_WR_C;
      end
      alc_pkg::ST_SZ_WR_C: begin
        s_we = 1'b1;
        s_addr_w = bc;
        s_wdata = '0;
        state_next = alc_pkg::ST_DONE;
      end
      alc_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = alc_pkg::ST_IDLE;
        end
      end
      default: state_next = alc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= alc_pkg::ST_IDLE;
      out_valid <= 1'b0;
      p_v       <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_load || (out_valid && out_stall);
      p_v       <= (state == alc_pkg::ST_SCAN);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p_i <= scan_i;
    p_j <= scan_j;
    // compare the cell read last cycle; first strict minimum wins
    if (p_v && (d_rdata < best)) begin
      best  <= d_rdata;
      br    <= IW'(p_i);
      bc    <= IW'(p_j);
      found <= 1'b1;
    end
    case (state)
      alc_pkg::ST_IDLE: begin
        scan_i <= CW'(1);
        scan_j <= '0;
        best   <= above;
        br     <= IW'(1);
        bc     <= '0;
        found  <= 1'b0;
      end
      alc_pkg::ST_SCAN: begin
        if (scan_j + 1'b1 == scan_i) begin
          scan_j <= '0;
          scan_i <= scan_i + 1'b1;
        end else begin
          scan_j <= scan_j + 1'b1;
        end
      end
      alc_pkg::ST_CLEAR: upd_i <= '0;
      alc_pkg::ST_SZ_R:  s_row <= s_rdata;
      alc_pkg::ST_SZ_C:  s_col <= s_rdata;
      alc_pkg::ST_UPD_CHK: begin
        if (skip_i && (upd_i != n_use)) upd_i <= upd_i + 1'b1;
      end
      alc_pkg::ST_UPD_RD_R: d_row <= d_rdata;
      alc_pkg::ST_UPD_RD_C: d_col <= d_rdata;
      alc_pkg::ST_UPD_CALC: comb_val <= simple_val;
      alc_pkg::ST_UPD_DIV: begin
        if (div_done) comb_val <= div_quot;
      end
      alc_pkg::ST_UPD_WR_R: upd_i <= upd_i + 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.merged_row     <= alc_pkg::IDX_W'(br);
      out_data.merged_col     <= alc_pkg::IDX_W'(bc);
      out_data.merge_distance <= best;
      out_data.pair_found     <= found;
    end
  end

endmodule

>>> rtl/alc_avg_div.sv
`timescale 1ns / 1ps
module alc_avg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [alc_pkg::CELL_W-1:0]   d_row,
  input  logic [alc_pkg::CELL_W-1:0]   d_col,
  input  logic [alc_pkg::SIZE_W-1:0]   s_row,
  input  logic [alc_pkg::SIZE_W-1:0]   s_col,
  output logic                         done,
  output logic [alc_pkg::CELL_W-1:0]   quot
);
  localparam int unsigned NW = alc_pkg::CELL_W + alc_pkg::SIZE_W + 1;
  localparam int unsigned DW = alc_pkg::SIZE_W + 1;
  localparam int unsigned CNT_W = $clog2(NW);

  alc_pkg::div_phase_t phase, phase_next;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    acc;
  logic [DW:0]      rem;
  logic [DW-1:0]    den;
  logic [alc_pkg::CELL_W-1:0] dr, dc;
  logic [alc_pkg::SIZE_W-1:0] sr, sc;
  logic [NW-1:0]    pc, pr;
  logic [DW:0]      rem_sh;
  logic             q_bit;
  logic             last;

  always_comb begin
    pc = sc[cnt[$clog2(alc_pkg::SIZE_W)-1:0]] ? (NW'(dc) << cnt) : '0;
    pr = sr[cnt[$clog2(alc_pkg::SIZE_W)-1:0]] ? (NW'(dr) << cnt) : '0;
    rem_sh = {rem[DW-1:0], acc[NW-1]};
    q_bit = (rem_sh >= (DW+1)'(den));
    phase_next = phase;
    last = 1'b0;
    case (phase)
      alc_pkg::DP_IDLE: begin
        if (start) phase_next = alc_pkg::DP_MUL;
      end
      alc_pkg::DP_MUL: begin
        if (cnt == CNT_W'(alc_pkg::SIZE_W - 1)) phase_next = alc_pkg::DP_DIV;
      end
      alc_pkg::DP_DIV: begin
        if (cnt == CNT_W'(NW - 1)) begin
          last = 1'b1;
          phase_next = alc_pkg::DP_IDLE;
        end
      end
      default: phase_next = alc_pkg::DP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= alc_pkg::DP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= last;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      alc_pkg::DP_IDLE: begin
        dr  <= d_row;
        dc  <= d_col;
        sr  <= s_row;
        sc  <= s_col;
        den <= DW'(s_row) + DW'(s_col);
        acc <= '0;
        rem <= '0;
        cnt <= '0;
      end
      alc_pkg::DP_MUL: begin
        // one size bit per cycle, both products at once
        acc <= acc + pc + pr;
        cnt <= (cnt == CNT_W'(alc_pkg::SIZE_W - 1)) ? '0 : cnt + 1'b1;
      end
      alc_pkg::DP_DIV: begin
        // restoring step: numerator shifts out, quotient shifts in
        rem <= q_bit ? (rem_sh - (DW+1)'(den)) : rem_sh;
        acc <= {acc[NW-2:0], q_bit};
        cnt <= cnt + 1'b1;
      end
      default: cnt <= '0;
    endcase
  end

  assign quot = acc[alc_pkg::CELL_W-1:0];

endmodule

>>> rtl/alc_checker.sv
`timescale 1ns / 1ps
`include "agglomerative_linkage_clusterer_assert.svh"
module alc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input alc_pkg::in_item_t             in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input alc_pkg::out_item_t            out_data,
  input logic                          cfg_we,
  input logic [alc_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [alc_pkg::CFG_W-1:0]     cfg_data
);
  logic unused_inputs;
  assign unused_inputs = ^{in_data, cfg_we, cfg_index, cfg_data};

  // a waiting result holds
  `ALC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

  // no pair found falls back to row 1, column 0
  `ALC_ASSERT_NOW(a_fallback, clk, rst, out_valid && !out_data.pair_found, out_data.merged_row == 1 && out_data.merged_col == 0)

  // a found pair is a lower-triangle cell
  `ALC_ASSERT_NOW(a_lower, clk, rst, out_valid && out_data.pair_found, out_data.merged_col < out_data.merged_row)

  // a merge never finishes in the cycle after it is taken
  `ALC_ASSERT_NEXT(a_no_instant, clk, rst, in_valid && !in_stall && in_data.req_type == alc_pkg::REQ_MERGE && !out_valid, !out_valid)

endmodule

bind agglomerative_linkage_clusterer alc_checker u_alc_checker (.*);
